@@ rtl/core/tpm_pkg.sv @@
// Shared types, constants and command codes for the truncated polynomial MAC.
package tpm_pkg;

	localparam int DEG_W         = 6;
	localparam int COEFF_W       = 32;
	localparam int ACC_W         = 48;
	localparam int SUM_W         = 50;
	localparam int PROD_W        = 64;
	localparam int RED_W         = 44;
	localparam int CMD_W         = 2;
	localparam int MAX_TERMS_DEF = 64;
	localparam int QUEUE_DEPTH   = 4;

	localparam logic [DEG_W-1:0] MAX_DEGREE_RST = 6'd63;

	localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
	localparam logic [CMD_W-1:0] CMD_MAC  = 2'd1;
	localparam logic [CMD_W-1:0] CMD_EMIT = 2'd2;

	typedef enum logic [1:0] {
		OP_LOAD,
		OP_MAC,
		OP_EMIT
	} op_t;

	typedef struct packed {
		op_t                       op;
		logic [DEG_W-1:0]          idx;
		logic signed [COEFF_W-1:0] lcoef;
		logic signed [COEFF_W-1:0] rcoef;
	} q_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MAC,
		ST_MAC_DRAIN,
		ST_EMIT,
		ST_EMIT_DRAIN
	} back_state_t;

endpackage

@@ rtl/core/tpm_front.sv @@
// Front end: accepts input transactions, decodes and filters them, queues them for the back end.
module tpm_front import tpm_pkg::*; #(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [CMD_W-1:0]          command,
	input  logic [DEG_W-1:0]          coeff_index,
	input  logic signed [COEFF_W-1:0] left_coeff,
	input  logic signed [COEFF_W-1:0] right_coeff,
	output logic                      q_vld,
	output q_item_t                   q_item,
	input  logic                      q_pop
);

	localparam int QP_W = $clog2(QUEUE_DEPTH);
	localparam logic [QP_W:0]  Q_FULL   = (QP_W+1)'(QUEUE_DEPTH);
	localparam logic [DEG_W:0] TERM_CNT = (DEG_W+1)'(MAX_TERMS);

	q_item_t          q_mem [QUEUE_DEPTH];
	logic [QP_W-1:0]  wr_ptr_q;
	logic [QP_W-1:0]  rd_ptr_q;
	logic [QP_W:0]    cnt_q;
	logic             keep;
	op_t              op;
	logic             push;

	always_comb begin
		keep = 1'b0;
		op   = OP_LOAD;
		case (command)
			CMD_LOAD: begin
				keep = ({1'b0, coeff_index} < TERM_CNT);
				op   = OP_LOAD;
			end
			CMD_MAC: begin
				keep = 1'b1;
				op   = OP_MAC;
			end
			CMD_EMIT: begin
				keep = 1'b1;
				op   = OP_EMIT;
			end
			default: begin
				keep = 1'b0;
				op   = OP_LOAD;
			end
		endcase
	end

	assign in_stall = (cnt_q == Q_FULL);
	assign push     = in_valid && !in_stall && keep;
	assign q_vld    = (cnt_q != '0);
	assign q_item   = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= '{op: op, idx: coeff_index, lcoef: left_coeff,
				rcoef: right_coeff};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (q_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !q_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (!push && q_pop) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ rtl/core/tpm_back.sv @@
// Back end: coefficient stores, convolution sequencer with MAC pipeline, accumulator and emit stream.
module tpm_back import tpm_pkg::*; #(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [DEG_W-1:0]          max_degree,
	input  logic                      q_vld,
	input  q_item_t                   q_item,
	output logic                      q_pop,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [DEG_W-1:0]          out_degree,
	output logic signed [COEFF_W-1:0] out_coeff,
	output logic                      last
);

	localparam int IDX_W = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam logic [DEG_W-1:0] TOP_LIM = DEG_W'(MAX_TERMS - 1);

	back_state_t state_q;
	back_state_t state_nxt;

	logic [COEFF_W-1:0] l_mem   [MAX_TERMS];
	logic [COEFF_W-1:0] r_mem   [MAX_TERMS];
	logic [ACC_W-1:0]   acc_mem [MAX_TERMS];
	logic [MAX_TERMS-1:0] ab_vld_q;
	logic [MAX_TERMS-1:0] acc_vld_q;

	logic [DEG_W-1:0] top_deg;
	logic [DEG_W-1:0] deg_q;
	logic [DEG_W-1:0] term_q;
	logic [DEG_W-1:0] b_diff;
	logic [IDX_W-1:0] a_idx;
	logic [IDX_W-1:0] b_idx;
	logic [IDX_W-1:0] acc_raddr;
	logic             deg_last;
	logic             term_last;

	logic ld_we;
	logic m_issue;
	logic e_issue;
	logic e_move;
	logic acc_ren;

	// mac pipeline
	logic                      m_vld_s1, m_first_s1, m_last_s1;
	logic [DEG_W-1:0]          m_deg_s1;
	logic [COEFF_W-1:0]        l_rd_q, r_rd_q;
	logic                      l_hit_s1, r_hit_s1;
	logic [ACC_W-1:0]          acc_rd_q;
	logic                      acc_hit_q;
	logic signed [COEFF_W-1:0] a_s1, b_s1;

	logic                      m_vld_s2, m_first_s2, m_last_s2;
	logic [DEG_W-1:0]          m_deg_s2;
	logic signed [PROD_W-1:0]  prod_s2;
	logic [ACC_W-1:0]          acc_s2;

	logic                      m_vld_s3;
	logic [DEG_W-1:0]          m_deg_s3;
	logic [ACC_W-1:0]          acc_s3;
	logic [SUM_W-1:0]          sum_q;
	logic [SUM_W-1:0]          sum_nxt;
	logic [RED_W-1:0]          red;
	logic [ACC_W+2:0]          tot;
	logic [ACC_W-1:0]          acc_wdata;

	// emit pipeline
	logic                      e_vld_s1, e_last_s1;
	logic [DEG_W-1:0]          e_deg_s1;
	logic [ACC_W-1:0]          e_val;
	logic [ACC_W-11:0]         e_sh;
	logic [COEFF_W-1:0]        e_sat;
	logic                      out_vld_q, out_last_q;
	logic [DEG_W-1:0]          out_deg_q;
	logic [COEFF_W-1:0]        out_coeff_q;

	assign top_deg   = (max_degree > TOP_LIM) ? TOP_LIM : max_degree;
	assign deg_last  = (deg_q == top_deg);
	assign term_last = (term_q == deg_q);
	assign b_diff    = deg_q - term_q;
	assign a_idx     = term_q[IDX_W-1:0];
	assign b_idx     = b_diff[IDX_W-1:0];
	assign acc_raddr = deg_q[IDX_W-1:0];
	assign e_move    = e_vld_s1 && (!out_vld_q || !out_stall);

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_vld) begin
					case (q_item.op)
						OP_MAC:  state_nxt = ST_MAC;
						OP_EMIT: state_nxt = ST_EMIT;
						default: state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_MAC: begin
				if (term_last && deg_last) begin
					state_nxt = ST_MAC_DRAIN;
				end
			end
			ST_MAC_DRAIN: begin
				if (!m_vld_s1 && !m_vld_s2 && !m_vld_s3) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_EMIT: begin
				if (e_issue && deg_last) begin
					state_nxt = ST_EMIT_DRAIN;
				end
			end
			ST_EMIT_DRAIN: begin
				if (!e_vld_s1) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		q_pop   = 1'b0;
		m_issue = 1'b0;
		e_issue = 1'b0;
		case (state_q)
			ST_IDLE: q_pop   = q_vld;
			ST_MAC:  m_issue = 1'b1;
			ST_EMIT: e_issue = !e_vld_s1 || e_move;
			default: begin
				q_pop   = 1'b0;
				m_issue = 1'b0;
				e_issue = 1'b0;
			end
		endcase
	end

	assign ld_we   = q_pop && (q_item.op == OP_LOAD);
	assign acc_ren = (m_issue && term_last) || e_issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			deg_q   <= '0;
			term_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (q_pop) begin
				deg_q  <= '0;
				term_q <= '0;
			end else if (m_issue) begin
				if (term_last) begin
					term_q <= '0;
					if (!deg_last) begin
						deg_q <= deg_q + 1'b1;
					end
				end else begin
					term_q <= term_q + 1'b1;
				end
			end else if (e_issue && !deg_last) begin
				deg_q <= deg_q + 1'b1;
			end
		end
	end

	// coefficient stores
	always_ff @(posedge clk) begin
		if (ld_we) begin
			l_mem[q_item.idx[IDX_W-1:0]] <= q_item.lcoef;
			r_mem[q_item.idx[IDX_W-1:0]] <= q_item.rcoef;
		end
		if (m_issue) begin
			l_rd_q <= l_mem[a_idx];
			r_rd_q <= r_mem[b_idx];
		end
	end

	// accumulator store
	always_ff @(posedge clk) begin
		if (m_vld_s3) begin
			acc_mem[m_deg_s3[IDX_W-1:0]] <= acc_wdata;
		end
		if (acc_ren) begin
			acc_rd_q <= acc_mem[acc_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ab_vld_q  <= '0;
			acc_vld_q <= '0;
			acc_hit_q <= 1'b0;
			l_hit_s1  <= 1'b0;
			r_hit_s1  <= 1'b0;
		end else begin
			if (ld_we) begin
				ab_vld_q[q_item.idx[IDX_W-1:0]] <= 1'b1;
			end
			if (m_issue) begin
				l_hit_s1 <= ab_vld_q[a_idx];
				r_hit_s1 <= ab_vld_q[b_idx];
			end
			if (acc_ren) begin
				acc_hit_q <= acc_vld_q[acc_raddr];
			end
			if (e_issue && deg_last) begin
				acc_vld_q <= '0;
			end else if (m_vld_s3) begin
				acc_vld_q[m_deg_s3[IDX_W-1:0]] <= 1'b1;
			end
		end
	end

	assign a_s1 = l_hit_s1 ? $signed(l_rd_q) : '0;
	assign b_s1 = r_hit_s1 ? $signed(r_rd_q) : '0;

	// product reduced to Q.40 by floor shift
	assign red     = prod_s2[PROD_W-1:20];
	assign sum_nxt = (m_first_s2 ? '0 : sum_q) + {{(SUM_W-RED_W){red[RED_W-1]}}, red};
	assign tot     = {{3{acc_s3[ACC_W-1]}}, acc_s3} + {sum_q[SUM_W-1], sum_q};

	always_comb begin
		if (tot[ACC_W+2:ACC_W-1] == '0 || tot[ACC_W+2:ACC_W-1] == '1) begin
			acc_wdata = tot[ACC_W-1:0];
		end else if (tot[ACC_W+2]) begin
			acc_wdata = {1'b1, {(ACC_W-1){1'b0}}};
		end else begin
			acc_wdata = {1'b0, {(ACC_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_s1 <= 1'b0;
			m_vld_s2 <= 1'b0;
			m_vld_s3 <= 1'b0;
		end else begin
			m_vld_s1 <= m_issue;
			m_vld_s2 <= m_vld_s1;
			m_vld_s3 <= m_vld_s2 && m_last_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (m_issue) begin
			m_first_s1 <= (term_q == '0);
			m_last_s1  <= term_last;
			m_deg_s1   <= deg_q;
		end
		if (m_vld_s1) begin
			prod_s2    <= a_s1 * b_s1;
			m_first_s2 <= m_first_s1;
			m_last_s2  <= m_last_s1;
			m_deg_s2   <= m_deg_s1;
			if (m_last_s1) begin
				acc_s2 <= acc_hit_q ? acc_rd_q : '0;
			end
		end
		if (m_vld_s2) begin
			sum_q <= sum_nxt;
			if (m_last_s2) begin
				acc_s3   <= acc_s2;
				m_deg_s3 <= m_deg_s2;
			end
		end
	end

	// emit: Q8.40 floor-shifted to Q8.30 and saturated to Q2.30
	assign e_val = acc_hit_q ? acc_rd_q : '0;
	assign e_sh  = e_val[ACC_W-1:10];

	always_comb begin
		if (e_sh[ACC_W-11:COEFF_W-1] == '0 || e_sh[ACC_W-11:COEFF_W-1] == '1) begin
			e_sat = e_sh[COEFF_W-1:0];
		end else if (e_sh[ACC_W-11]) begin
			e_sat = {1'b1, {(COEFF_W-1){1'b0}}};
		end else begin
			e_sat = {1'b0, {(COEFF_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_vld_s1  <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (e_issue) begin
				e_vld_s1 <= 1'b1;
			end else if (e_move) begin
				e_vld_s1 <= 1'b0;
			end
			if (e_move) begin
				out_vld_q <= 1'b1;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (e_issue) begin
			e_deg_s1  <= deg_q;
			e_last_s1 <= deg_last;
		end
		if (e_move) begin
			out_deg_q   <= e_deg_s1;
			out_coeff_q <= e_sat;
			out_last_q  <= e_last_s1;
		end
	end

	assign out_valid  = out_vld_q;
	assign out_degree = out_deg_q;
	assign out_coeff  = $signed(out_coeff_q);
	assign last       = out_last_q;

endmodule

@@ rtl/core/truncated_poly_mac.sv @@
// Top level of the truncated polynomial multiply-accumulate engine.
// Load, multiply-accumulate and emit transactions enter a four-deep queue, and the back end
// takes each one from the queue when it is idle. The input side keeps taking transactions
// while the engine works and while an emitted coefficient waits on out_stall, until
// the queue is full. With T = min(max_degree, MAX_TERMS-1), one 32x32 multiplier walks
// every product of the truncated convolution once during a multiply-accumulate. An emit
// sends T+1 coefficients at one per cycle while out_stall is low, and then clears the
// accumulator.
module truncated_poly_mac import tpm_pkg::*; #(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [DEG_W-1:0]          cfg_wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [CMD_W-1:0]          command,
	input  logic [DEG_W-1:0]          coeff_index,
	input  logic signed [COEFF_W-1:0] left_coeff,
	input  logic signed [COEFF_W-1:0] right_coeff,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [DEG_W-1:0]          out_degree,
	output logic signed [COEFF_W-1:0] out_coeff,
	output logic                      last
);

	logic [DEG_W-1:0] max_degree_q;
	logic             q_vld;
	q_item_t          q_item;
	logic             q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_degree_q <= MAX_DEGREE_RST;
		end else if (cfg_wr_en) begin
			max_degree_q <= cfg_wr_data;
		end
	end

	tpm_front #(.MAX_TERMS(MAX_TERMS)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.command     (command),
		.coeff_index (coeff_index),
		.left_coeff  (left_coeff),
		.right_coeff (right_coeff),
		.q_vld       (q_vld),
		.q_item      (q_item),
		.q_pop       (q_pop)
	);

	tpm_back #(.MAX_TERMS(MAX_TERMS)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.max_degree (max_degree_q),
		.q_vld      (q_vld),
		.q_item     (q_item),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_degree (out_degree),
		.out_coeff  (out_coeff),
		.last       (last)
	);

endmodule

@@ rtl/core/tpm_checker.sv @@
// Port-level assertions for the truncated polynomial MAC, bound to the top level.
module tpm_checker import tpm_pkg::*; #(
	parameter int MAX_TERMS = MAX_TERMS_DEF
) (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      cfg_wr_en,
	input logic [DEG_W-1:0]          cfg_wr_data,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic [DEG_W-1:0]          out_degree,
	input logic signed [COEFF_W-1:0] out_coeff,
	input logic                      last
);

	localparam logic [DEG_W-1:0] TOP_LIM = DEG_W'(MAX_TERMS - 1);

	logic [DEG_W-1:0] mdeg_q;
	logic [DEG_W-1:0] top_deg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mdeg_q <= MAX_DEGREE_RST;
		end else if (cfg_wr_en) begin
			mdeg_q <= cfg_wr_data;
		end
	end

	assign top_deg = (mdeg_q > TOP_LIM) ? TOP_LIM : mdeg_q;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_degree)
			&& $stable(out_coeff) && $stable(last))
		else $error("stalled result transaction changed");

	a_last_top: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last |-> out_degree == top_deg)
		else $error("last flag not on top degree");

	a_nonlast_below: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> out_degree < top_deg)
		else $error("result degree beyond top degree");

	a_degree_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> !out_valid
			|| out_degree == $past(out_degree) + 6'd1)
		else $error("emitted degrees not consecutive");

	a_restart_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && last |=> !out_valid || out_degree == '0)
		else $error("new emit does not start at degree zero");

endmodule

bind truncated_poly_mac tpm_checker #(.MAX_TERMS(MAX_TERMS)) u_tpm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.cfg_wr_en   (cfg_wr_en),
	.cfg_wr_data (cfg_wr_data),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.out_degree  (out_degree),
	.out_coeff   (out_coeff),
	.last        (last)
);
